/* rtl/pst_pkg.sv */
// Package for the process state table: command/response types, chain token, codes.
`timescale 1ns / 1ps

package pst_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int PID_WIDTH_DEF   = 16;

    typedef enum logic [2:0] {
        ACT_CREATE    = 3'd0,
        ACT_TERMINATE = 3'd1,
        ACT_EXISTS    = 3'd2,
        ACT_ADMIT     = 3'd3,
        ACT_DISPATCH  = 3'd4,
        ACT_PREEMPT   = 3'd5,
        ACT_BLOCK     = 3'd6,
        ACT_WAKEUP    = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        RC_OK          = 3'd0,
        RC_BAD_PARAMS  = 3'd1,
        RC_EXHAUSTED   = 3'd2,
        RC_FULL        = 3'd3,
        RC_NOT_FOUND   = 3'd4,
        RC_WRONG_STATE = 3'd5,
        RC_INVALID_PID = 3'd6
    } rc_t;

    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_WAITING = 2'd3
    } pstate_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_ACT,
        CS_RESULT
    } ctl_state_t;

    typedef struct packed {
        action_t            action;
        logic [15:0]        target_pid;
        logic signed [15:0] priority_req;
        logic signed [31:0] burst_time;
        logic signed [31:0] memory_usage;
    } cmd_t;

    typedef struct packed {
        rc_t         result_code;
        logic [15:0] result_pid;
        logic        found;
        pstate_t     process_state;
        logic [14:0] entry_priority;
        logic [30:0] entry_burst;
        logic [30:0] entry_memory;
    } rsp_t;

    // Token moving down the cell row: a probe gathers free/held status,
    // a command token is served by the first matching cell.
    typedef struct packed {
        logic        active;
        logic        probe;
        action_t     action;
        logic        done;
        logic        held;
        logic        free_seen;
        rc_t         code;
        pstate_t     state;
        logic [14:0] prio;
        logic [30:0] burst;
        logic [30:0] mem;
    } tok_t;

endpackage

/* rtl/pst_cell.sv */
// One table slot of the process state table with its token stage.
`timescale 1ns / 1ps

module pst_cell
    import pst_pkg::*;
#(
    parameter int PID_WIDTH = PID_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tok_t                 tok_in,
    input  logic [PID_WIDTH-1:0] key_in,
    output tok_t                 tok_out,
    output logic [PID_WIDTH-1:0] key_out
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [PID_WIDTH-1:0] pid_reg;
    pstate_t              state_reg;
    pstate_t              state_next;
    logic [14:0]          prio_reg;
    logic [30:0]          burst_reg;
    logic [30:0]          mem_reg;
    tok_t                 tok_reg;
    tok_t                 tok_next;
    logic [PID_WIDTH-1:0] key_reg;
    logic                 wr_entry;
    logic                 hit;
    logic                 is_trans;
    pstate_t              need;
    pstate_t              to;

    assign hit = valid_reg && (pid_reg == key_in);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        state_next = state_reg;
        wr_entry   = 1'b0;
        is_trans   = 1'b0;
        need       = ST_NEW;
        to         = ST_READY;
        if (tok_in.active)
        begin
            if (tok_in.probe)
            begin
                if (!valid_reg)
                    tok_next.free_seen = 1'b1;
                if (hit)
                    tok_next.held = 1'b1;
            end
            else if (!tok_in.done)
            begin
                if (tok_in.action == ACT_CREATE)
                begin
                    // take the first free slot along the row
                    if (!valid_reg)
                    begin
                        wr_entry       = 1'b1;
                        valid_next     = 1'b1;
                        state_next     = ST_NEW;
                        tok_next.done  = 1'b1;
                        tok_next.code  = RC_OK;
                        tok_next.state = ST_NEW;
                    end
                end
                else if (hit)
                begin
                    tok_next.done  = 1'b1;
                    tok_next.code  = RC_OK;
                    tok_next.state = state_reg;
                    tok_next.prio  = prio_reg;
                    tok_next.burst = burst_reg;
                    tok_next.mem   = mem_reg;
                    case (tok_in.action)
                        ACT_TERMINATE: valid_next = 1'b0;
                        ACT_EXISTS:    is_trans = 1'b0;
                        ACT_ADMIT:
                        begin
                            is_trans = 1'b1; need = ST_NEW;     to = ST_READY;
                        end
                        ACT_DISPATCH:
                        begin
                            is_trans = 1'b1; need = ST_READY;   to = ST_RUNNING;
                        end
                        ACT_PREEMPT:
                        begin
                            is_trans = 1'b1; need = ST_RUNNING; to = ST_READY;
                        end
                        ACT_BLOCK:
                        begin
                            is_trans = 1'b1; need = ST_RUNNING; to = ST_WAITING;
                        end
                        default:
                        begin
                            is_trans = 1'b1; need = ST_WAITING; to = ST_READY;
                        end
                    endcase
                    if (is_trans)
                    begin
                        if (state_reg == need)
                        begin
                            state_next     = to;
                            tok_next.state = to;
                        end
                        else
                        begin
                            tok_next.code = RC_WRONG_STATE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_in;
        if (wr_entry)
        begin
            pid_reg   <= key_in;
            prio_reg  <= tok_in.prio;
            burst_reg <= tok_in.burst;
            mem_reg   <= tok_in.mem;
        end
    end

    assign tok_out = tok_reg;
    assign key_out = key_reg;

endmodule

/* rtl/process_state_table.sv */
// Process state table top level: command sequencer driving a row of slot cells.
// Exists on pid zero or a create with a negative parameter goes straight to its result;
// other non-create commands send one command token down the cell row; create first
// sends a probe pass, a single probe or PROBES probes once the pid counter
// is at its maximum (probes walk the cell row one slot per cycle).
// One command at a time; the next is taken once the result moves to the output register.
// Reset clears slot valid bits and the pid counter; slot contents stay as they are.
`timescale 1ns / 1ps

module process_state_table
    import pst_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int PID_WIDTH   = PID_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam longint PID_MAX_L = (longint'(1) << PID_WIDTH) - 1;
    localparam int     PROBES    = (longint'(TABLE_SLOTS + 1) < PID_MAX_L - 1)
                                   ? TABLE_SLOTS + 1 : int'(PID_MAX_L - 1);
    localparam int     CNT_W     = $clog2(PROBES + 1);

    ctl_state_t           state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [PID_WIDTH-1:0] key_reg, key_next;
    logic [PID_WIDTH-1:0] next_pid_reg, next_pid_next;
    logic [PID_WIDTH-1:0] cand_reg, cand_next;
    logic                 search_reg, search_next;
    logic                 got_reg, got_next;
    logic [CNT_W-1:0]     inj_cnt_reg, inj_cnt_next;
    logic [CNT_W-1:0]     exit_cnt_reg, exit_cnt_next;
    logic [CNT_W-1:0]     inj_total;
    logic [CNT_W-1:0]     inj_cnt_p1;
    rsp_t                 res_reg, res_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    tok_t                 tok_chain [TABLE_SLOTS+1];
    logic [PID_WIDTH-1:0] key_chain [TABLE_SLOTS+1];
    tok_t                 inj_tok;
    logic [PID_WIDTH-1:0] inj_key;
    tok_t                 tail;
    logic [PID_WIDTH-1:0] tail_key;
    logic [31:0]          tgt32;
    logic [PID_WIDTH-1:0] tgt_key;
    logic [31:0]          key32;
    logic                 bad_params;
    logic                 got_now;
    logic [PID_WIDTH-1:0] cand_now;

    assign tail     = tok_chain[TABLE_SLOTS];
    assign tail_key = key_chain[TABLE_SLOTS];
    assign tgt32    = {16'b0, cmd.target_pid};
    assign tgt_key  = tgt32[PID_WIDTH-1:0];
    assign key32    = 32'(key_reg);
    assign inj_total  = search_reg ? CNT_W'(PROBES) : CNT_W'(1);
    assign inj_cnt_p1 = inj_cnt_reg + CNT_W'(1);
    assign bad_params = cmd.priority_req[15] || cmd.burst_time[31] || cmd.memory_usage[31];
    assign got_now    = got_reg || (search_reg && !tail.held);
    assign cand_now   = got_reg ? cand_reg : tail_key;

    assign tok_chain[0] = inj_tok;
    assign key_chain[0] = inj_key;

    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        pst_cell #(
            .PID_WIDTH(PID_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[i]),
            .key_in  (key_chain[i]),
            .tok_out (tok_chain[i+1]),
            .key_out (key_chain[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        next_pid_next  = next_pid_reg;
        cand_next      = cand_reg;
        search_next    = search_reg;
        got_next       = got_reg;
        inj_cnt_next   = inj_cnt_reg;
        exit_cnt_next  = exit_cnt_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        inj_tok        = '0;
        inj_key        = key_reg;
        cmd_stall      = (state_reg != CS_IDLE);

        case (state_reg)
            CS_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = cmd;
                    key_next      = tgt_key;
                    inj_cnt_next  = '0;
                    exit_cnt_next = '0;
                    got_next      = 1'b0;
                    search_next   = (next_pid_reg == '1);
                    res_next      = '0;
                    if (cmd.action == ACT_CREATE)
                    begin
                        if (bad_params)
                        begin
                            res_next.result_code = RC_BAD_PARAMS;
                            state_next           = CS_RESULT;
                        end
                        else
                        begin
                            state_next = CS_SCAN;
                        end
                    end
                    else if (cmd.action == ACT_EXISTS && tgt_key == '0)
                    begin
                        res_next.result_code = RC_INVALID_PID;
                        res_next.result_pid  = 16'(tgt_key);
                        state_next           = CS_RESULT;
                    end
                    else
                    begin
                        state_next = CS_ACT;
                    end
                end
            end

            CS_SCAN:
            begin
                // feed probes: candidate pids 1, 2, ... when searching
                if (inj_cnt_reg < inj_total)
                begin
                    inj_tok.active = 1'b1;
                    inj_tok.probe  = 1'b1;
                    inj_key        = PID_WIDTH'(inj_cnt_p1);
                    inj_cnt_next   = inj_cnt_p1;
                end
                if (tail.active && tail.probe)
                begin
                    exit_cnt_next = exit_cnt_reg + CNT_W'(1);
                    got_next      = got_now;
                    cand_next     = cand_now;
                    if (exit_cnt_reg == inj_total - CNT_W'(1))
                    begin
                        inj_cnt_next = '0;
                        if (!tail.free_seen)
                        begin
                            res_next.result_code = RC_FULL;
                            state_next           = CS_RESULT;
                        end
                        else if (search_reg && !got_now)
                        begin
                            res_next.result_code = RC_EXHAUSTED;
                            state_next           = CS_RESULT;
                        end
                        else if (search_reg)
                        begin
                            key_next      = cand_now;
                            next_pid_next = cand_now + PID_WIDTH'(1);
                            state_next    = CS_ACT;
                        end
                        else
                        begin
                            key_next      = next_pid_reg;
                            next_pid_next = next_pid_reg + PID_WIDTH'(1);
                            state_next    = CS_ACT;
                        end
                    end
                end
            end

            CS_ACT:
            begin
                if (inj_cnt_reg == '0)
                begin
                    inj_tok.active = 1'b1;
                    inj_tok.action = cmd_reg.action;
                    inj_tok.state  = ST_NEW;
                    inj_tok.prio   = cmd_reg.priority_req[14:0];
                    inj_tok.burst  = cmd_reg.burst_time[30:0];
                    inj_tok.mem    = cmd_reg.memory_usage[30:0];
                    inj_cnt_next   = CNT_W'(1);
                end
                if (tail.active && !tail.probe)
                begin
                    res_next            = '0;
                    res_next.result_pid = key32[15:0];
                    if (!tail.done)
                    begin
                        res_next.result_code = RC_NOT_FOUND;
                    end
                    else
                    begin
                        res_next.result_code    = tail.code;
                        res_next.found          = 1'b1;
                        res_next.process_state  = tail.state;
                        res_next.entry_priority = tail.prio;
                        res_next.entry_burst    = tail.burst;
                        res_next.entry_memory   = tail.mem;
                    end
                    state_next = CS_RESULT;
                end
            end

            CS_RESULT:
            begin
                // hand over once the output register is free or draining
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end

            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            next_pid_reg  <= '0;
            search_reg    <= 1'b0;
            got_reg       <= 1'b0;
            inj_cnt_reg   <= '0;
            exit_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_pid_reg  <= next_pid_next;
            search_reg    <= search_next;
            got_reg       <= got_next;
            inj_cnt_reg   <= inj_cnt_next;
            exit_cnt_reg  <= exit_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        cand_reg <= cand_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a create token only runs after a probe pass saw a free slot
    a_create_served: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.active && !tail.probe && tail.action == ACT_CREATE) |-> tail.done)
        else $error("create token left the cell row unserved");

    // all probes have drained before the command token runs
    a_no_late_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_ACT) |-> !(tail.active && tail.probe))
        else $error("probe token seen during command pass");

    // the pid counter only moves at the end of a probe pass
    a_pid_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(next_pid_reg) |-> ($past(state_reg) == CS_SCAN && state_reg == CS_ACT))
        else $error("pid counter changed outside allocation");

endmodule

/* sim/tb_process_state_table.sv */
// Testbench for the process state table: directed table plus random command traffic.
`timescale 1ns / 1ps

module tb_process_state_table;
    import pst_pkg::*;

    localparam int          SLOTS        = TABLE_SLOTS_DEF;
    localparam logic [15:0] PID_TOP      = 16'hFFFF;
    localparam int          RANDOM_ITEMS = 1675;
    localparam int          IDLE_PCT     = 23;
    localparam int          STALL_HOLD   = 400;
    localparam int          TAIL_CYCLES  = 64;

    typedef struct {
        cmd_t c;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // shadow copy of the process table
    bit          held [SLOTS];
    logic [15:0] pid_of [SLOTS];
    pstate_t     st_of [SLOTS];
    logic [14:0] prio_of [SLOTS];
    logic [30:0] burst_of [SLOTS];
    logic [30:0] mem_of [SLOTS];
    logic [15:0] pid_next;

    rsp_t      pending_rsp[$];
    stim_row_t plan[$];
    int        fail_count = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;

    process_state_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int find_slot(logic [15:0] p);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (held[i] && pid_of[i] == p)
                return i;
        end
        return -1;
    endfunction

    function automatic rsp_t slot_view(int s);
        rsp_t r;
        r = '0;
        r.found          = 1'b1;
        r.process_state  = st_of[s];
        r.entry_priority = prio_of[s];
        r.entry_burst    = burst_of[s];
        r.entry_memory   = mem_of[s];
        return r;
    endfunction

    // Advance the shadow table by one command and return the response it gives.
    function automatic rsp_t apply_cmd(cmd_t c);
        rsp_t        r;
        int          s;
        logic [15:0] npid;
        bit          got;
        pstate_t     need_st;
        pstate_t     next_st;
        r = '0;
        if (c.action == ACT_CREATE)
        begin
            if (c.priority_req[15] || c.burst_time[31] || c.memory_usage[31])
            begin
                r.result_code = RC_BAD_PARAMS;
                return r;
            end
            s = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (!held[i])
                    s = i;
            end
            if (s < 0)
            begin
                r.result_code = RC_FULL;
                return r;
            end
            got = 1'b0;
            npid = '0;
            if (pid_next < PID_TOP)
            begin
                npid = pid_next;
                pid_next = pid_next + 16'd1;
                got = 1'b1;
            end
            else
            begin
                // counter saturated: take the lowest free pid above zero
                for (int p = 1; p < PID_TOP && !got; p++)
                begin
                    if (find_slot(p[15:0]) < 0)
                    begin
                        npid = p[15:0];
                        pid_next = npid + 16'd1;
                        got = 1'b1;
                    end
                end
            end
            if (!got)
            begin
                r.result_code = RC_EXHAUSTED;
                return r;
            end
            held[s]     = 1'b1;
            pid_of[s]   = npid;
            st_of[s]    = ST_NEW;
            prio_of[s]  = c.priority_req[14:0];
            burst_of[s] = c.burst_time[30:0];
            mem_of[s]   = c.memory_usage[30:0];
            r = slot_view(s);
            r.result_pid = npid;
            return r;
        end

        r.result_pid = c.target_pid;
        if (c.action == ACT_EXISTS && c.target_pid == 16'd0)
        begin
            r.result_code = RC_INVALID_PID;
            return r;
        end
        s = find_slot(c.target_pid);
        if (s < 0)
        begin
            r.result_code = RC_NOT_FOUND;
            return r;
        end
        r = slot_view(s);
        r.result_pid = c.target_pid;
        case (c.action)
            ACT_TERMINATE: held[s] = 1'b0;
            ACT_EXISTS: ;
            default:
            begin
                case (c.action)
                    ACT_ADMIT:    begin need_st = ST_NEW;     next_st = ST_READY;   end
                    ACT_DISPATCH: begin need_st = ST_READY;   next_st = ST_RUNNING; end
                    ACT_PREEMPT:  begin need_st = ST_RUNNING; next_st = ST_READY;   end
                    ACT_BLOCK:    begin need_st = ST_RUNNING; next_st = ST_WAITING; end
                    default:      begin need_st = ST_WAITING; next_st = ST_READY;   end
                endcase
                if (st_of[s] == need_st)
                begin
                    st_of[s] = next_st;
                    r.process_state = next_st;
                end
                else
                    r.result_code = RC_WRONG_STATE;
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t mk_cmd(action_t a, logic [15:0] pid, logic [15:0] pr,
                                    logic [31:0] bu, logic [31:0] me);
        cmd_t c;
        c.action       = a;
        c.target_pid   = pid;
        c.priority_req = pr;
        c.burst_time   = bu;
        c.memory_usage = me;
        return c;
    endfunction

    function automatic rsp_t mk_rsp(rc_t rc, logic [15:0] pid, logic f, pstate_t st,
                                    logic [14:0] pr, logic [30:0] bu, logic [30:0] me);
        rsp_t r;
        r.result_code    = rc;
        r.result_pid     = pid;
        r.found          = f;
        r.process_state  = st;
        r.entry_priority = pr;
        r.entry_burst    = bu;
        r.entry_memory   = me;
        return r;
    endfunction

    task automatic add_row(cmd_t c, bit typed, rsp_t want);
        stim_row_t row;
        row.c     = c;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // Mostly well-formed traffic: targets are live pids and the transition
    // usually fits the entry's current state.
    function automatic cmd_t gen_cmd(int grow_pct, int kill_pct);
        cmd_t        c;
        logic [15:0] live[$];
        int          pick;
        int          s;
        c.action       = ACT_CREATE;
        c.target_pid   = 16'($urandom);
        c.priority_req = 16'($urandom);
        c.burst_time   = $urandom;
        c.memory_usage = $urandom;
        if ($urandom_range(99) < grow_pct)
        begin
            if ($urandom_range(99) < 88)
            begin
                c.priority_req[15] = 1'b0;
                c.burst_time[31]   = 1'b0;
                c.memory_usage[31] = 1'b0;
            end
            return c;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (held[i])
                live.push_back(pid_of[i]);
        end
        pick = $urandom_range(99);
        if (live.size() != 0 && pick < 80)
            c.target_pid = live[$urandom_range(live.size() - 1)];
        else if (pick < 92)
            c.target_pid = 16'($urandom_range(int'(pid_next) + 2));
        s = find_slot(c.target_pid);
        if ($urandom_range(99) < kill_pct)
            c.action = ACT_TERMINATE;
        else if (s >= 0 && $urandom_range(99) < 65)
        begin
            case (st_of[s])
                ST_NEW:     c.action = ACT_ADMIT;
                ST_READY:   c.action = ACT_DISPATCH;
                ST_RUNNING: c.action = $urandom_range(1) ? ACT_PREEMPT : ACT_BLOCK;
                default:    c.action = ACT_WAKEUP;
            endcase
        end
        else
            c.action = action_t'($urandom_range(7, 1));
        return c;
    endfunction

    // Offer one command, hold it through stalls, and log its expected response.
    task automatic send_cmd(cmd_t c, bit typed, rsp_t want);
        rsp_t guess;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd = c;
        cmd_valid = 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        guess = apply_cmd(c);
        pending_rsp.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    task automatic note_diff(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: response with nothing expected, expected none, got %h",
                         $time, rsp);
            end
            else
            begin
                want = pending_rsp.pop_front();
                note_diff("result_code", want.result_code, rsp.result_code);
                note_diff("result_pid", want.result_pid, rsp.result_pid);
                note_diff("found", want.found, rsp.found);
                note_diff("process_state", want.process_state, rsp.process_state);
                note_diff("entry_priority", want.entry_priority, rsp.entry_priority);
                note_diff("entry_burst", want.entry_burst, rsp.entry_burst);
                note_diff("entry_memory", want.entry_memory, rsp.entry_memory);
            end
        end
    end

    // Response side: random stalls, plus one long hold-off to back up the block.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_stall = 1'b1;
                repeat (STALL_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            rsp_stall = rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int grow_pct [6];
        int kill_pct [6];
        int ph;
        grow_pct = '{30, 85, 15, 5, 60, 40};
        kill_pct = '{10, 2, 8, 45, 5, 20};
        for (int i = 0; i < SLOTS; i++)
            held[i] = 1'b0;
        pid_next = '0;

        add_row(mk_cmd(ACT_EXISTS, 16'h0000, '0, '0, '0), 1'b1,
                mk_rsp(RC_INVALID_PID, 16'h0000, 1'b0, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_TERMINATE, 16'h0005, '0, '0, '0), 1'b1,
                mk_rsp(RC_NOT_FOUND, 16'h0005, 1'b0, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_CREATE, 16'h0000, 16'h8000, '0, '0), 1'b1,
                mk_rsp(RC_BAD_PARAMS, 16'h0000, 1'b0, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_CREATE, 16'hFFFF, '0, 32'h8000_0000, '0), 1'b1,
                mk_rsp(RC_BAD_PARAMS, 16'h0000, 1'b0, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_CREATE, 16'h0000, 16'h7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                mk_rsp(RC_BAD_PARAMS, 16'h0000, 1'b0, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_CREATE, 16'h0000, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
                mk_rsp(RC_OK, 16'h0000, 1'b1, ST_NEW, 15'h7FFF, 31'h7FFF_FFFF,
                       31'h7FFF_FFFF));
        add_row(mk_cmd(ACT_CREATE, 16'hFFFF, '0, '0, '0), 1'b1,
                mk_rsp(RC_OK, 16'h0001, 1'b1, ST_NEW, '0, '0, '0));
        // pid zero is held now, exists still rejects it
        add_row(mk_cmd(ACT_EXISTS, 16'h0000, '0, '0, '0), 1'b1,
                mk_rsp(RC_INVALID_PID, 16'h0000, 1'b0, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_EXISTS, 16'h0001, '0, '0, '0), 1'b1,
                mk_rsp(RC_OK, 16'h0001, 1'b1, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_ADMIT, 16'h0000, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_DISPATCH, 16'h0000, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_PREEMPT, 16'h0000, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_DISPATCH, 16'h0000, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_BLOCK, 16'h0000, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_BLOCK, 16'h0000, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_WAKEUP, 16'h0000, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_PREEMPT, 16'h0001, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_WAKEUP, 16'h0001, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_DISPATCH, 16'h0001, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_TERMINATE, 16'h0000, '0, '0, '0), 1'b0, '0);
        add_row(mk_cmd(ACT_ADMIT, 16'h0000, '0, '0, '0), 1'b1,
                mk_rsp(RC_NOT_FOUND, 16'h0000, 1'b0, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_EXISTS, 16'hFFFF, '0, '0, '0), 1'b1,
                mk_rsp(RC_NOT_FOUND, 16'hFFFF, 1'b0, ST_NEW, '0, '0, '0));
        // reuses slot zero with the next counted pid
        add_row(mk_cmd(ACT_CREATE, 16'hAAAA, 16'h5555, 32'h2AAA_AAAA, 32'h1234_5678),
                1'b0, '0);
        add_row(mk_cmd(ACT_TERMINATE, 16'hFFFF, '0, '0, '0), 1'b1,
                mk_rsp(RC_NOT_FOUND, 16'hFFFF, 1'b0, ST_NEW, '0, '0, '0));
        add_row(mk_cmd(ACT_BLOCK, 16'h0002, '0, '0, '0), 1'b0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[k])
            send_cmd(plan[k].c, plan[k].typed, plan[k].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            ph = (n / 100) % 6;
            calm = (n >= 700 && n < 1000);
            if (n == 1300)
                hold_req = 1'b1;
            send_cmd(gen_cmd(grow_pct[ph], kill_pct[ph]), 1'b0, '0);
        end
        cmd_valid = 1'b0;
        calm = 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
